// ----- design/flash_log_parameter_store_unit_assert.svh -----
// assertion macros for the flash log parameter store checker
// depends on nothing; included by the checker file only
`ifndef FLASH_LOG_PARAMETER_STORE_UNIT_ASSERT_SVH
`define FLASH_LOG_PARAMETER_STORE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FLPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flps assertion failed");

// next-cycle implication, disabled in reset
`define FLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flps assertion failed");

// next-cycle implication that also covers reset
`define FLPS_ASSERT_RAW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("flps assertion failed");

`endif

// ----- design/flps_pkg.sv -----
// shared types and constants of the flash log parameter store
// depends on nothing
package flps_pkg;

  localparam logic [31:0] LOG_MAGIC   = 32'h7473_6170;
  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] ASTRAY_MASK = 32'hFF00_0000;
  localparam logic [11:0] SLEN_MAX    = 12'hFFF;

  typedef enum logic [2:0] {
    CMD_FORMAT = 3'd0,
    CMD_CHECK  = 3'd1,
    CMD_SIZE   = 3'd2,
    CMD_WBEGIN = 3'd3,
    CMD_WDATA  = 3'd4,
    CMD_READ   = 3'd5,
    CMD_ERASE  = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  typedef enum logic [4:0] {
    UOP_NONE, UOP_ACCEPT, UOP_CLR, UOP_FMT, UOP_RD0, UOP_M0C,
    UOP_LK_INIT_E, UOP_LK_INIT_I, UOP_LK_RID, UOP_LK_EVAL, UOP_LK_ADV,
    UOP_CHK, UOP_SETEND, UOP_SIZE, UOP_SAVE_OLD,
    UOP_HID_RD, UOP_HID_WR, UOP_HLEN_RD, UOP_HLEN_WR, UOP_WB_FIN, UOP_ZOLD,
    UOP_WD_RD, UOP_WD_WR, UOP_RD_LEN, UOP_RD_LC, UOP_RD_DC, UOP_ER
  } uop_t;

  typedef struct packed {
    logic clr_last;
    logic end_nz;
    logic wb_fit;
    logic lk_stop;
    logic lk_nz;
    logic pend;
    logic wl_last;
    logic old_nz;
    logic len_zero;
  } dp_status_t;

endpackage

// ----- design/flps_dp.sv -----
// datapath: flash sector memory, log pointers, lookup walker and result registers
// depends on flps_pkg
module flps_dp #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  flps_pkg::uop_t       op,
  input  logic [23:0]          in_unit_id,
  input  logic [11:0]          in_unit_length_in,
  input  logic [9:0]           in_word_index,
  input  logic [31:0]          in_data_word,
  output flps_pkg::dp_status_t status,
  output logic                 out_ok,
  output logic [31:0]          out_value,
  output logic [11:0]          out_stored_length
);
  import flps_pkg::*;

  localparam int DEPTH = STORE_BYTES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = $clog2(STORE_BYTES) + 1;
  localparam int RW    = ((OW > 13) ? OW : 13) + 1;
  localparam int GW    = RW + 1;
  localparam logic [RW-1:0] SB_R     = RW'(STORE_BYTES);
  localparam logic [GW-1:0] SB_G     = GW'(STORE_BYTES);
  localparam logic [33:0]   SB_L     = 34'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;
  logic          oor_r;

  // control state
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [OW-1:0] end_r, end_nxt;
  logic [10:0]   wl_r, wl_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [OW-1:0] old_r, old_nxt;
  logic [11:0]   plen_r, plen_nxt;

  // payload
  logic [23:0]   id_r, id_nxt;
  logic [11:0]   len_r, len_nxt;
  logic [9:0]    widx_r, widx_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [OW-1:0] lk_a_r, lk_a_nxt;
  logic          lk_erased_r, lk_erased_nxt;
  logic [OW-1:0] lk_res_r, lk_res_nxt;
  logic          magic_r, magic_nxt;
  logic [31:0]   sl_r, sl_nxt;
  logic          ok_r, ok_nxt;
  logic [31:0]   value_r, value_nxt;
  logic [11:0]   slen_r, slen_nxt;

  logic [31:0]   rd_eff;
  logic          lk_match, lk_end;
  logic [33:0]   a_sum, a_rnd;
  logic [OW-1:0] a_next;
  logic [12:0]   pad_len, pad_plen;
  logic [GW-1:0] fit_sum;
  logic [RW-1:0] e_sum, e8, e4;
  logic [RW-1:0] rd_off;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic [31:0]   padmask;

  assign rd_eff   = oor_r ? ERASED_WORD : rdata_r;
  assign lk_match = lk_erased_r ? (rd_eff == ERASED_WORD) : (rd_eff == {8'h00, id_r});
  assign lk_end   = (rd_eff == ERASED_WORD) || ((rd_eff & ASTRAY_MASK) != 32'h0);

  // next header: past id, length and padded data
  assign a_sum  = 34'(lk_a_r) + 34'd11 + {2'b00, rd_eff};
  assign a_rnd  = {a_sum[33:2], 2'b00};
  assign a_next = (a_rnd >= SB_L) ? OW'(STORE_BYTES) : a_rnd[OW-1:0];

  assign pad_len  = ({1'b0, len_r} + 13'd3) & ~13'd3;
  assign pad_plen = ({1'b0, plen_r} + 13'd3) & ~13'd3;
  assign fit_sum  = GW'(end_r) + GW'(8) + GW'(pad_len);
  assign e_sum    = RW'(end_r) + RW'(8) + RW'(pad_plen);
  assign e8       = RW'(end_r) + RW'(8);
  assign e4       = RW'(end_r) + RW'(4);
  assign padmask  = ((wl_r == 11'd1) && (plen_r[1:0] != 2'b00)) ?
                    (ERASED_WORD << {plen_r[1:0], 3'b000}) : 32'h0;

  assign status.clr_last = (clr_idx_r == LAST_IDX);
  assign status.end_nz   = (end_r != '0);
  assign status.wb_fit   = (end_r != '0) && (fit_sum <= SB_G);
  assign status.lk_stop  = lk_match || lk_end;
  assign status.lk_nz    = (lk_res_r != '0);
  assign status.pend     = (wl_r != '0);
  assign status.wl_last  = (wl_r == 11'd1);
  assign status.old_nz   = (old_r != '0);
  assign status.len_zero = (len_r == '0);

  // read address
  always_comb begin
    case (op)
      UOP_LK_RID:  rd_off = RW'(lk_a_r);
      UOP_LK_EVAL: rd_off = RW'(lk_a_r) + RW'(4);
      UOP_HID_RD:  rd_off = RW'(end_r);
      UOP_HLEN_RD: rd_off = e4;
      UOP_WD_RD:   rd_off = RW'({wp_r, 2'b00});
      UOP_RD_LEN:  rd_off = RW'(lk_res_r) + RW'(4);
      UOP_RD_LC:   rd_off = RW'(lk_res_r) + RW'(8) + RW'({in_word_index & 10'h0, 2'b00})
                            + RW'({widx_r, 2'b00});
      default:     rd_off = '0;
    endcase
  end

  // write port, bits are only ever cleared outside the erase sweep
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = ERASED_WORD;
    case (op)
      UOP_CLR: begin
        we = 1'b1;
        wa = clr_idx_r;
      end
      UOP_FMT: begin
        we = 1'b1;
        wa = clr_idx_r;
        wd = (clr_idx_r == '0) ? LOG_MAGIC : ERASED_WORD;
      end
      UOP_HID_WR: begin
        we = 1'b1;
        wa = end_r[AW+1:2];
        wd = rd_eff & {8'h00, id_r};
      end
      UOP_HLEN_WR: begin
        we = 1'b1;
        wa = e4[AW+1:2];
        wd = rd_eff & {20'h0, len_r};
      end
      UOP_ZOLD: begin
        we = 1'b1;
        wa = old_r[AW+1:2];
        wd = 32'h0;
      end
      UOP_WD_WR: begin
        we = 1'b1;
        wa = wp_r;
        wd = rd_eff & (data_r | padmask);
      end
      UOP_ER: begin
        we = (lk_res_r != '0);
        wa = lk_res_r[AW+1:2];
        wd = 32'h0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_off[AW+1:2]];
    oor_r   <= (rd_off >= SB_R);
  end

  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    end_nxt       = end_r;
    wl_nxt        = wl_r;
    wp_nxt        = wp_r;
    old_nxt       = old_r;
    plen_nxt      = plen_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    widx_nxt      = widx_r;
    data_nxt      = data_r;
    lk_a_nxt      = lk_a_r;
    lk_erased_nxt = lk_erased_r;
    lk_res_nxt    = lk_res_r;
    magic_nxt     = magic_r;
    sl_nxt        = sl_r;
    ok_nxt        = ok_r;
    value_nxt     = value_r;
    slen_nxt      = slen_r;
    case (op)
      UOP_ACCEPT: begin
        id_nxt    = in_unit_id;
        len_nxt   = in_unit_length_in;
        widx_nxt  = in_word_index;
        data_nxt  = in_data_word;
        ok_nxt    = 1'b0;
        value_nxt = 32'h0;
        slen_nxt  = 12'h0;
      end
      UOP_CLR: begin
        clr_idx_nxt = (clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + AW'(1);
      end
      UOP_FMT: begin
        clr_idx_nxt = (clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_IDX) begin
          end_nxt = OW'(4);
          ok_nxt  = 1'b1;
        end
      end
      UOP_M0C:       magic_nxt = (rd_eff == LOG_MAGIC);
      UOP_LK_INIT_E: begin
        lk_a_nxt      = OW'(4);
        lk_erased_nxt = 1'b1;
      end
      UOP_LK_INIT_I: begin
        lk_a_nxt      = OW'(4);
        lk_erased_nxt = 1'b0;
      end
      UOP_LK_EVAL: begin
        if (lk_match) begin
          lk_res_nxt = lk_a_r;
        end else if (lk_end) begin
          lk_res_nxt = '0;
        end
      end
      UOP_LK_ADV:    lk_a_nxt = a_next;
      UOP_CHK: begin
        end_nxt = lk_res_r;
        ok_nxt  = magic_r && (lk_res_r != '0);
      end
      UOP_SETEND:    end_nxt = lk_res_r;
      UOP_SIZE: begin
        if (end_r != '0) begin
          value_nxt = 32'(end_r);
          ok_nxt    = 1'b1;
        end
      end
      UOP_SAVE_OLD:  old_nxt = lk_res_r;
      UOP_WB_FIN: begin
        ok_nxt = 1'b1;
        if (len_r == '0) begin
          end_nxt = e8[OW-1:0];
        end else begin
          plen_nxt = len_r;
          wl_nxt   = pad_len[12:2];
          wp_nxt   = e8[AW+1:2];
        end
      end
      UOP_ZOLD:      old_nxt = '0;
      UOP_WD_WR: begin
        wp_nxt = wp_r + AW'(1);
        wl_nxt = wl_r - 11'd1;
        ok_nxt = 1'b1;
        if (wl_r == 11'd1) begin
          end_nxt = e_sum[OW-1:0];
        end
      end
      UOP_RD_LC: begin
        sl_nxt   = rd_eff;
        slen_nxt = (rd_eff > 32'(SLEN_MAX)) ? SLEN_MAX : rd_eff[11:0];
      end
      UOP_RD_DC: begin
        if (32'({widx_r, 2'b00}) < sl_r) begin
          value_nxt = rd_eff;
          ok_nxt    = 1'b1;
        end
      end
      UOP_ER: begin
        if (lk_res_r != '0) begin
          ok_nxt = 1'b1;
        end
      end
      default: begin
        ok_nxt = ok_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      end_r     <= '0;
      wl_r      <= '0;
      wp_r      <= '0;
      old_r     <= '0;
      plen_r    <= '0;
    end else begin
      clr_idx_r <= clr_idx_nxt;
      end_r     <= end_nxt;
      wl_r      <= wl_nxt;
      wp_r      <= wp_nxt;
      old_r     <= old_nxt;
      plen_r    <= plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    len_r       <= len_nxt;
    widx_r      <= widx_nxt;
    data_r      <= data_nxt;
    lk_a_r      <= lk_a_nxt;
    lk_erased_r <= lk_erased_nxt;
    lk_res_r    <= lk_res_nxt;
    magic_r     <= magic_nxt;
    sl_r        <= sl_nxt;
    ok_r        <= ok_nxt;
    value_r     <= value_nxt;
    slen_r      <= slen_nxt;
  end

  assign out_ok            = ok_r;
  assign out_value         = value_r;
  assign out_stored_length = slen_r;

endmodule

// ----- design/flps_ctrl.sv -----
// controller: command sequencer issuing datapath micro-operations
// depends on flps_pkg
module flps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           in_cmd,
  input  flps_pkg::dp_status_t status,
  output flps_pkg::uop_t       op,
  output logic                 busy,
  output logic                 out_valid
);
  import flps_pkg::*;

  typedef enum logic [26:0] {
    S_CLR   = 27'd1 << 0,
    S_IDLE  = 27'd1 << 1,
    S_RESP  = 27'd1 << 2,
    S_M0    = 27'd1 << 3,
    S_M0C   = 27'd1 << 4,
    S_CHK   = 27'd1 << 5,
    S_LKE   = 27'd1 << 6,
    S_LKI   = 27'd1 << 7,
    S_LKID  = 27'd1 << 8,
    S_LKIDC = 27'd1 << 9,
    S_LKLEN = 27'd1 << 10,
    S_SETE  = 27'd1 << 11,
    S_SIZE  = 27'd1 << 12,
    S_WBG   = 27'd1 << 13,
    S_WBH   = 27'd1 << 14,
    S_HIDR  = 27'd1 << 15,
    S_HIDW  = 27'd1 << 16,
    S_HLENR = 27'd1 << 17,
    S_HLENW = 27'd1 << 18,
    S_WBF   = 27'd1 << 19,
    S_ZOLD  = 27'd1 << 20,
    S_RDA   = 27'd1 << 21,
    S_RDL   = 27'd1 << 22,
    S_RDD   = 27'd1 << 23,
    S_ER    = 27'd1 << 24,
    S_WDR   = 27'd1 << 25,
    S_WDW   = 27'd1 << 26
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  cmd_t   cmd_r, cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd_nxt   = cmd_r;
    op        = UOP_NONE;
    case (state_r)
      S_CLR: begin
        op = (cmd_r == CMD_FORMAT) ? UOP_FMT : UOP_CLR;
        if (status.clr_last) begin
          state_nxt = (cmd_r == CMD_FORMAT) ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op      = UOP_ACCEPT;
          cmd_nxt = cmd_t'(in_cmd);
          if (cmd_t'(in_cmd) == CMD_WDATA) begin
            state_nxt = status.pend ? S_WDR : S_RESP;
          end else if (status.pend) begin
            state_nxt = S_RESP;
          end else begin
            case (cmd_t'(in_cmd))
              CMD_FORMAT: state_nxt = S_CLR;
              CMD_CHECK:  state_nxt = S_M0;
              CMD_SIZE, CMD_WBEGIN: begin
                if (status.end_nz) begin
                  state_nxt = (cmd_t'(in_cmd) == CMD_SIZE) ? S_SIZE : S_WBG;
                end else begin
                  state_nxt = S_LKE;
                  ret_nxt   = S_SETE;
                end
              end
              CMD_READ: begin
                state_nxt = S_LKI;
                ret_nxt   = S_RDA;
              end
              CMD_ERASE: begin
                state_nxt = S_LKI;
                ret_nxt   = S_ER;
              end
              default: state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_M0: begin
        op        = UOP_RD0;
        state_nxt = S_M0C;
      end
      S_M0C: begin
        op        = UOP_M0C;
        state_nxt = S_LKE;
        ret_nxt   = S_CHK;
      end
      S_CHK: begin
        op        = UOP_CHK;
        state_nxt = S_RESP;
      end
      S_LKE: begin
        op        = UOP_LK_INIT_E;
        state_nxt = S_LKID;
      end
      S_LKI: begin
        op        = UOP_LK_INIT_I;
        state_nxt = S_LKID;
      end
      S_LKID: begin
        op        = UOP_LK_RID;
        state_nxt = S_LKIDC;
      end
      S_LKIDC: begin
        op        = UOP_LK_EVAL;
        state_nxt = status.lk_stop ? ret_r : S_LKLEN;
      end
      S_LKLEN: begin
        op        = UOP_LK_ADV;
        state_nxt = S_LKID;
      end
      S_SETE: begin
        op        = UOP_SETEND;
        state_nxt = (cmd_r == CMD_SIZE) ? S_SIZE : S_WBG;
      end
      S_SIZE: begin
        op        = UOP_SIZE;
        state_nxt = S_RESP;
      end
      S_WBG: begin
        if (status.wb_fit) begin
          state_nxt = S_LKI;
          ret_nxt   = S_WBH;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_WBH: begin
        op        = UOP_SAVE_OLD;
        state_nxt = S_HIDR;
      end
      S_HIDR: begin
        op        = UOP_HID_RD;
        state_nxt = S_HIDW;
      end
      S_HIDW: begin
        op        = UOP_HID_WR;
        state_nxt = S_HLENR;
      end
      S_HLENR: begin
        op        = UOP_HLEN_RD;
        state_nxt = S_HLENW;
      end
      S_HLENW: begin
        op        = UOP_HLEN_WR;
        state_nxt = S_WBF;
      end
      S_WBF: begin
        op        = UOP_WB_FIN;
        state_nxt = (status.len_zero && status.old_nz) ? S_ZOLD : S_RESP;
      end
      S_ZOLD: begin
        op        = UOP_ZOLD;
        state_nxt = S_RESP;
      end
      S_RDA: begin
        op        = UOP_RD_LEN;
        state_nxt = status.lk_nz ? S_RDL : S_RESP;
      end
      S_RDL: begin
        op        = UOP_RD_LC;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        op        = UOP_RD_DC;
        state_nxt = S_RESP;
      end
      S_ER: begin
        op        = UOP_ER;
        state_nxt = S_RESP;
      end
      S_WDR: begin
        op        = UOP_WD_RD;
        state_nxt = S_WDW;
      end
      S_WDW: begin
        op        = UOP_WD_WR;
        state_nxt = (status.wl_last && status.old_nz) ? S_ZOLD : S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r   <= S_IDLE;
      cmd_r   <= CMD_NONE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

// ----- design/flash_log_parameter_store_unit.sv -----
// flash log parameter store: one command at a time, result strobe out_valid
// refused commands go straight to the response; lookups grow with each unit header passed over,
// a write begin with no known end walks the log twice, reading id then length per header
// throughput: next command accepted the cycle after out_valid; no stall input
// reset and format run a sweep over all STORE_BYTES/4 sector words with busy high
// depends on flps_pkg, flps_ctrl, flps_dp
module flash_log_parameter_store_unit #(
  parameter int STORE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [23:0] in_unit_id,
  input  logic [11:0] in_unit_length_in,
  input  logic [9:0]  in_word_index,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  output logic        out_ok,
  output logic [31:0] out_value,
  output logic [11:0] out_stored_length
);
  import flps_pkg::*;

  // micro-operation from the sequencer, flags back from the datapath
  uop_t       op;
  dp_status_t status;

  // sequencer: accepts a transaction, walks the log, strobes the result
  flps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // sector memory, log pointers and result registers
  flps_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .in_unit_id        (in_unit_id),
    .in_unit_length_in (in_unit_length_in),
    .in_word_index     (in_word_index),
    .in_data_word      (in_data_word),
    .status            (status),
    .out_ok            (out_ok),
    .out_value         (out_value),
    .out_stored_length (out_stored_length)
  );

endmodule

// ----- design/flps_chk.sv -----
// port-level checker for the flash log parameter store, bound to the top level
// depends on flash_log_parameter_store_unit_assert.svh
`include "flash_log_parameter_store_unit_assert.svh"

module flps_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `FLPS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `FLPS_ASSERT_SAME(a_result_busy, clk, rst_n, out_valid, busy)
  `FLPS_ASSERT_NEXT(a_result_once, clk, rst_n, out_valid, !out_valid && !busy)
  `FLPS_ASSERT_RAW(a_reset_sweep, clk, !rst_n, busy && !out_valid)

endmodule

bind flash_log_parameter_store_unit flps_chk u_flps_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- verif/tb.sv -----
// self-checking testbench for flash_log_parameter_store_unit
// depends on flps_pkg and the unit's rtl; a behavioural model of the sector log
`timescale 1ns / 1ps

module tb;
  import flps_pkg::*;

  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_WORDS = SECTOR_BYTES / 4;
  localparam int RANDOM_ITEMS = 1800;
  // the limit outlasts a full log walk or a sector sweep, gaps are short
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    cmd_t        cmd;
    logic [23:0] id;
    logic [11:0] len;
    logic [9:0]  widx;
    logic [31:0] data;
    int          idle_pct;
  } command_t;

  typedef struct {
    logic        ok;
    logic [31:0] value;
    logic [11:0] slen;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [23:0] in_unit_id = '0;
  logic [11:0] in_unit_length_in = '0;
  logic [9:0]  in_word_index = '0;
  logic [31:0] in_data_word = '0;
  logic        out_valid;
  logic        out_ok;
  logic [31:0] out_value;
  logic [11:0] out_stored_length;

  // commands waiting for the driver, answers waiting for the unit
  command_t pending_cmds[$];
  answer_t  awaited_answers[$];

  // model of the sector and the write state
  logic [31:0] sector[SECTOR_WORDS];
  int unsigned log_end;
  int unsigned wr_words_left;
  int unsigned wr_ptr;
  int unsigned wr_old_hdr;
  int unsigned wr_len;

  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          cmd_counts[8];
  int          ok_count = 0;
  int          answer_count = 0;
  logic        took_cmd = 1'b0;

  flash_log_parameter_store_unit #(.STORE_BYTES(SECTOR_BYTES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_unit_id(in_unit_id), .in_unit_length_in(in_unit_length_in),
    .in_word_index(in_word_index), .in_data_word(in_data_word),
    .out_valid(out_valid), .out_ok(out_ok), .out_value(out_value),
    .out_stored_length(out_stored_length)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- model

  // words past the sector read as erased
  function automatic logic [31:0] sector_word(longint unsigned off);
    if (off >= SECTOR_BYTES) return ERASED_WORD;
    return sector[off >> 2];
  endfunction

  // flash programming only clears bits
  function automatic void sector_program(longint unsigned off, logic [31:0] v);
    if (off < SECTOR_BYTES) sector[off >> 2] &= v;
  endfunction

  function automatic void sector_erase();
    foreach (sector[i]) sector[i] = ERASED_WORD;
  endfunction

  // walk the unit chain; header offset of a match, else 0
  function automatic int unsigned find_unit(logic [31:0] id);
    longint unsigned a;
    logic [31:0] cid;
    logic [31:0] clen;
    a = 4;
    forever begin
      cid = sector_word(a);
      clen = sector_word(a + 4);
      if (cid == id) return (a > SECTOR_BYTES) ? SECTOR_BYTES : int'(a);
      if (cid == ERASED_WORD || (cid & ASTRAY_MASK) != 0) return 0;
      a = (a + 8 + clen + 3) & ~longint'(3);
    end
  endfunction

  function automatic int unsigned pad4(int unsigned n);
    return (n + 3) & ~32'd3;
  endfunction

  function automatic answer_t predict_answer(command_t c);
    answer_t r;
    logic [31:0] d;
    int unsigned old_hdr;
    int unsigned hdr;
    logic [31:0] sl;
    r = '{ok: 1'b0, value: '0, slen: '0};
    if (c.cmd == CMD_WDATA) begin
      if (wr_words_left != 0) begin
        d = c.data;
        // bytes beyond the unit length stay erased
        if (wr_words_left == 1 && wr_len[1:0] != 0) d |= ERASED_WORD << (8 * wr_len[1:0]);
        sector_program(longint'(wr_ptr) * 4, d);
        wr_ptr++;
        wr_words_left--;
        if (wr_words_left == 0) begin
          log_end += 8 + pad4(wr_len);
          if (wr_old_hdr != 0) sector_program(wr_old_hdr, '0);
          wr_old_hdr = 0;
        end
        r.ok = 1'b1;
      end
    end else if (wr_words_left == 0) begin
      case (c.cmd)
        CMD_FORMAT: begin
          sector_erase();
          sector[0] = LOG_MAGIC;
          log_end = find_unit(ERASED_WORD);
          r.ok = log_end != 0;
        end
        CMD_CHECK: begin
          log_end = find_unit(ERASED_WORD);
          r.ok = sector[0] == LOG_MAGIC && log_end != 0;
        end
        CMD_SIZE: begin
          if (log_end == 0) log_end = find_unit(ERASED_WORD);
          if (log_end != 0) begin
            r.value = log_end;
            r.ok = 1'b1;
          end
        end
        CMD_WBEGIN: begin
          if (log_end == 0) log_end = find_unit(ERASED_WORD);
          if (log_end != 0 && longint'(log_end) + 8 + pad4(c.len) <= SECTOR_BYTES) begin
            old_hdr = find_unit({8'h00, c.id});
            sector_program(log_end, {8'h00, c.id});
            sector_program(longint'(log_end) + 4, {20'h0, c.len});
            if (c.len == 0) begin
              log_end += 8;
              if (old_hdr != 0) sector_program(old_hdr, '0);
            end else begin
              wr_len = c.len;
              wr_words_left = pad4(c.len) / 4;
              wr_ptr = (log_end + 8) / 4;
              wr_old_hdr = old_hdr;
            end
            r.ok = 1'b1;
          end
        end
        CMD_READ: begin
          hdr = find_unit({8'h00, c.id});
          if (hdr != 0) begin
            sl = sector_word(longint'(hdr) + 4);
            r.slen = (sl > SLEN_MAX) ? SLEN_MAX : sl[11:0];
            if (longint'(c.widx) * 4 < longint'(sl)) begin
              r.value = sector_word(longint'(hdr) + 8 + longint'(c.widx) * 4);
              r.ok = 1'b1;
            end
          end
        end
        CMD_ERASE: begin
          hdr = find_unit({8'h00, c.id});
          if (hdr != 0) begin
            sector_program(hdr, '0);
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  // new command at the falling edge once the last one was taken
  always @(negedge clk) begin
    command_t c;
    logic drive;
    drive = 1'b0;
    if (rst_n && (!start || took_cmd) && pending_cmds.size() > 0) begin
      if ($urandom_range(99) >= pending_cmds[0].idle_pct) begin
        c = pending_cmds.pop_front();
        drive = 1'b1;
        in_cmd <= c.cmd;
        in_unit_id <= c.id;
        in_unit_length_in <= c.len;
        in_word_index <= c.widx;
        in_data_word <= c.data;
      end
    end
    if (!start || took_cmd) start <= drive;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    answer_t want;
    command_t c;
    took_cmd <= rst_n && start && !busy;
    if (rst_n) begin
      // answers first, a new transaction cannot answer in its own cycle
      if (out_valid) begin
        answer_count++;
        if (awaited_answers.size() == 0) begin
          $display("%0t: answer with none awaited: ok=%0b value=%h slen=%0d",
                   $time, out_ok, out_value, out_stored_length);
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b actual %0b", $time, want.ok, out_ok);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, want.value, out_value);
            fail_count++;
          end
          if (out_stored_length !== want.slen) begin
            $display("%0t: stored_length mismatch: expected %0d actual %0d",
                     $time, want.slen, out_stored_length);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        c.cmd = cmd_t'(in_cmd);
        c.id = in_unit_id;
        c.len = in_unit_length_in;
        c.widx = in_word_index;
        c.data = in_data_word;
        c.idle_pct = 0;
        awaited_answers.push_back(predict_answer(c));
        cmd_counts[in_cmd]++;
      end
      if (out_valid && out_ok) ok_count++;
      // watchdog on cycles with no transaction either way
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  int idle_now = 0;

  function automatic void queue_cmd(cmd_t cmd, logic [23:0] id = 24'd1,
                                    logic [11:0] len = '0, logic [9:0] widx = '0,
                                    logic [31:0] data = '0);
    command_t c;
    c.cmd = cmd;
    c.id = id;
    c.len = len;
    c.widx = widx;
    c.data = data;
    c.idle_pct = idle_now;
    pending_cmds.push_back(c);
  endfunction

  // write begin plus the data words of the unit
  function automatic void queue_unit(logic [23:0] id, logic [11:0] len);
    queue_cmd(CMD_WBEGIN, id, len, $urandom, $urandom);
    for (int i = 0; i < pad4(len) / 4; i++) queue_cmd(CMD_WDATA, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [23:0] pick_id();
    int k;
    k = $urandom_range(99);
    if (k < 85) return $urandom_range(8, 1);
    if (k < 92) return $urandom;
    if (k < 96) return 24'hFFFFFF;
    return 24'h0;
  endfunction

  function automatic logic [11:0] pick_len();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(24);
    if (k < 92) return $urandom_range(200);
    if (k < 97) return $urandom_range(4084);
    return $urandom;
  endfunction

  initial begin
    int phase_pct[4];
    int k;
    int base;
    phase_pct = '{0, 59, 0, 18};
    sector_erase();
    log_end = 0;
    wr_words_left = 0;
    wr_ptr = 0;
    wr_old_hdr = 0;
    wr_len = 0;
    foreach (cmd_counts[i]) cmd_counts[i] = 0;

    // directed part: unformatted sector, lengths, refusals, limits
    queue_cmd(CMD_CHECK);
    queue_cmd(CMD_SIZE);
    queue_cmd(CMD_WDATA, 24'd1, '0, '0, 32'hFFFF_FFFF);
    queue_cmd(CMD_NONE);
    queue_cmd(CMD_FORMAT);
    queue_cmd(CMD_CHECK);
    queue_cmd(CMD_WBEGIN, 24'd5, 12'd0);
    queue_cmd(CMD_WBEGIN, 24'hFFFFFF, 12'd5);
    queue_cmd(CMD_READ, 24'hFFFFFF);    // refused while a write is pending
    queue_cmd(CMD_WDATA, '0, '0, '0, 32'h0000_0000);
    queue_cmd(CMD_WDATA, '0, '0, '0, 32'hA5A5_A5A5);
    queue_cmd(CMD_READ, 24'hFFFFFF, '0, 10'd1);
    queue_cmd(CMD_READ, 24'hFFFFFF, '0, 10'd2);   // beyond the stored length
    queue_cmd(CMD_READ, 24'hFFFFFF, '0, 10'd1020);
    queue_cmd(CMD_WBEGIN, 24'd5, 12'd4);          // replaces the empty copy
    queue_cmd(CMD_WDATA, '0, '0, '0, 32'h1234_5678);
    queue_cmd(CMD_READ, 24'd5);
    queue_cmd(CMD_ERASE, 24'd5);
    queue_cmd(CMD_READ, 24'd0);                   // id zero hits a cleared header
    queue_cmd(CMD_READ, 24'd9);
    queue_cmd(CMD_WBEGIN, 24'd7, 12'd4084);       // overflow refused
    queue_cmd(CMD_SIZE);
    queue_cmd(CMD_FORMAT);
    queue_cmd(CMD_WBEGIN, 24'd7, 12'd4084);       // exactly fills the sector
    queue_cmd(CMD_SIZE);

    // random part in phases of sender idling
    base = pending_cmds.size();
    for (int ph = 0; ph < 4; ph++) begin
      idle_now = phase_pct[ph];
      queue_cmd(CMD_FORMAT);
      while (pending_cmds.size() - base < RANDOM_ITEMS * (ph + 1) / 4) begin
        k = $urandom_range(99);
        if (k < 45) queue_unit(pick_id(), pick_len());
        else if (k < 65) queue_cmd(CMD_READ, pick_id(), $urandom,
                                   ($urandom_range(3) == 0) ? $urandom : $urandom_range(8));
        else if (k < 72) queue_cmd(CMD_ERASE, pick_id());
        else if (k < 78) queue_cmd(CMD_SIZE, $urandom, $urandom, $urandom, $urandom);
        else if (k < 82) queue_cmd(CMD_CHECK, $urandom);
        else if (k < 85) queue_cmd(CMD_FORMAT, $urandom);
        else if (k < 88) queue_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
        else if (k < 92) queue_cmd(CMD_WDATA, $urandom, $urandom, $urandom, $urandom);
        else begin
          // broken sequence: another command cuts into a pending write
          queue_cmd(CMD_WBEGIN, pick_id(), $urandom_range(4, 40));
          queue_cmd(cmd_t'($urandom_range(6)), pick_id(), $urandom, $urandom, $urandom);
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || start || awaited_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands (format %0d, check %0d, size %0d, begin %0d, data %0d,",
             answer_count, cmd_counts[CMD_FORMAT], cmd_counts[CMD_CHECK],
             cmd_counts[CMD_SIZE], cmd_counts[CMD_WBEGIN], cmd_counts[CMD_WDATA]);
    $display("  read %0d, erase %0d, unused %0d), %0d answered ok, %0d mismatches",
             cmd_counts[CMD_READ], cmd_counts[CMD_ERASE], cmd_counts[CMD_NONE],
             ok_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
